/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

/* rtl/a85dec_pkg.sv */
package a85dec_pkg;

  localparam int unsigned GrpW     = 27;        // holds up to 85^4 - 1
  localparam int unsigned AccW     = 33;        // holds up to 85^5 - 1
  localparam int unsigned PowW     = 20;        // holds 85^3

  localparam logic [7:0]  CharBias = 8'd33;
  localparam logic [7:0]  DigitMax = 8'd84;
  localparam logic [7:0]  CharZ    = 8'h7A;     // 'z'
  localparam logic [6:0]  Radix    = 7'd85;

  localparam logic [2:0]  GroupLen = 3'd5;
  localparam logic [2:0]  MinTail  = 3'd2;

  localparam logic [PowW-1:0] Pow1 = 20'd85;
  localparam logic [PowW-1:0] Pow2 = 20'd7225;
  localparam logic [PowW-1:0] Pow3 = 20'd614125;

  // Kind of result bundle produced by one character.
  typedef enum logic [1:0] {
    K_NONE,
    K_BYTES,
    K_PAD,
    K_ERR
  } kind_e;

  // 85^(5-n): weight of the padding digits for a tail of n digits.
  function automatic logic [PowW-1:0] pad_pow(input logic [2:0] n);
    logic [PowW-1:0] p;
    unique case (n)
      3'd2:    p = Pow3;
      3'd3:    p = Pow2;
      default: p = Pow1;
    endcase
    return p;
  endfunction

endpackage

/* rtl/ascii85_stream_decoder.sv */
// Ascii85 stream decoder.
// Input channel: one character per word (char_in_i) with stream_last_i on
// the final character; accepted when in_valid_i is high and in_stall_o low.
// Output channel: one decoded byte per word with is_error_o, item_last_o
// and stream_end_o; taken when out_valid_o is high and out_stall_i low.
// Pipeline: input register -> digit accumulate / decode -> result register
// -> tail padding multiply -> output shift register. The first byte of an
// item goes from the input register via the result register to the output.
// Throughput: one character per cycle while characters only accumulate.
// An item yields k bytes (4 for a full group or 'z', n-1 for a tail of n
// digits, 1 for an error) and holds the output register until all k are
// taken, so the output port sets the rate; a full group of 5 gives 4 bytes.
// An error ends the stream's output; later characters up to the next
// stream_last_i are taken and dropped without results.
// Reset clears the pipeline valids, the group accumulator and the drop
// state. When the receiver stalls the output word holds, the stages behind
// it fill, and in_stall_o rises once the input register cannot drain.
`include "assert_macros.svh"

module ascii85_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       stream_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       is_error_o,
  output logic       item_last_o,
  output logic       stream_end_o
);

  localparam int unsigned GrpW = a85dec_pkg::GrpW;
  localparam int unsigned AccW = a85dec_pkg::AccW;
  localparam int unsigned PowW = a85dec_pkg::PowW;

  // ---------------- input register
  logic       s1_vld_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;

  // ---------------- group state
  logic [2:0]      cnt_q, cnt_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic            disc_q, disc_d;

  // ---------------- result register
  logic              s2_vld_q;
  a85dec_pkg::kind_e s2_kind_q;
  logic [31:0]       s2_val_q;
  logic [2:0]        s2_nb_q;
  logic              s2_last_q;

  // ---------------- output shift register
  logic [31:0] word_q;
  logic [2:0]  rem_q;
  logic        err_q;
  logic        end_q;

  // Handshake plumbing
  logic in_acc, out_acc;
  logic s1_adv, s2_adv, s2_free, s3_free;

  // Stage 1 decode
  a85dec_pkg::kind_e s1_kind;
  logic [31:0]       s1_val;
  logic [2:0]        s1_nb;
  logic [7:0]        digit;
  logic [AccW-1:0]   acc;
  logic [2:0]        cnt_new;

  // Stage 2 padding
  logic [PowW-1:0]      pw;
  logic [GrpW+PowW-1:0] prod;
  logic [AccW-1:0]      padded;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  // Output register frees up when empty or on the take of its last byte.
  assign s3_free     = (rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i);
  assign s2_adv      = s2_vld_q && s3_free;
  assign s2_free     = !s2_vld_q || s2_adv;
  assign s1_adv      = s1_vld_q && ((s1_kind == a85dec_pkg::K_NONE) || s2_free);
  assign in_stall_o  = s1_vld_q && !s1_adv;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Digit accumulate and group decision. acc < 85^5 fits 33 bits.
  assign digit   = s1_char_q - a85dec_pkg::CharBias;
  assign acc     = AccW'(grp_q) * AccW'(a85dec_pkg::Radix) + AccW'(digit);
  assign cnt_new = cnt_q + 3'd1;

  always_comb begin
    s1_kind = a85dec_pkg::K_NONE;
    s1_val  = 32'd0;
    s1_nb   = 3'd4;
    cnt_d   = cnt_q;
    grp_d   = grp_q;
    disc_d  = disc_q;
    if (disc_q) begin
      if (s1_last_q) begin
        disc_d = 1'b0;
        cnt_d  = 3'd0;
        grp_d  = '0;
      end
    end else if ((cnt_q == 3'd0) && (s1_char_q == a85dec_pkg::CharZ)) begin
      s1_kind = a85dec_pkg::K_BYTES;
    end else if (digit > a85dec_pkg::DigitMax) begin
      s1_kind = a85dec_pkg::K_ERR;
      cnt_d   = 3'd0;
      grp_d   = '0;
      disc_d  = !s1_last_q;
    end else if (cnt_new == a85dec_pkg::GroupLen) begin
      cnt_d = 3'd0;
      grp_d = '0;
      if (acc[AccW-1]) begin
        s1_kind = a85dec_pkg::K_ERR;
        disc_d  = !s1_last_q;
      end else begin
        s1_kind = a85dec_pkg::K_BYTES;
        s1_val  = acc[31:0];
      end
    end else if (s1_last_q) begin
      cnt_d = 3'd0;
      grp_d = '0;
      if (cnt_new < a85dec_pkg::MinTail) begin
        s1_kind = a85dec_pkg::K_ERR;
      end else begin
        // tail of cnt_new digits; value kept below 85^4
        s1_kind = a85dec_pkg::K_PAD;
        s1_val  = 32'(acc[GrpW-1:0]);
        s1_nb   = cnt_new - 3'd1;
      end
    end else begin
      cnt_d = cnt_new;
      grp_d = acc[GrpW-1:0];
    end
  end

  // Padding: v*85^m + (85^m - 1), m = 5 - n, n = bytes + 1.
  assign pw     = a85dec_pkg::pad_pow(s2_nb_q + 3'd1);
  assign prod   = s2_val_q[GrpW-1:0] * pw;
  assign padded = AccW'(prod) + AccW'(pw) - AccW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      rem_q    <= 3'd0;
      cnt_q    <= 3'd0;
      grp_q    <= '0;
      disc_q   <= 1'b0;
    end else begin
      // input register
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      // group state moves only when the character is consumed
      if (s1_adv) begin
        cnt_q  <= cnt_d;
        grp_q  <= grp_d;
        disc_q <= disc_d;
      end
      // result register
      if (s1_adv && (s1_kind != a85dec_pkg::K_NONE)) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
      // output shift register
      if (s2_adv) begin
        case (s2_kind_q)
          a85dec_pkg::K_BYTES: begin
            rem_q <= s2_nb_q;
          end
          a85dec_pkg::K_PAD: begin
            rem_q <= padded[AccW-1] ? 3'd1 : s2_nb_q;
          end
          default: begin
            rem_q <= 3'd1;
          end
        endcase
      end else if (out_acc) begin
        rem_q <= rem_q - 3'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q <= char_in_i;
      s1_last_q <= stream_last_i;
    end
    if (s1_adv && (s1_kind != a85dec_pkg::K_NONE)) begin
      s2_kind_q <= s1_kind;
      s2_val_q  <= s1_val;
      s2_nb_q   <= s1_nb;
      s2_last_q <= s1_last_q;
    end
    if (s2_adv) begin
      case (s2_kind_q)
        a85dec_pkg::K_BYTES: begin
          word_q <= s2_val_q;
          err_q  <= 1'b0;
          end_q  <= s2_last_q;
        end
        a85dec_pkg::K_PAD: begin
          if (padded[AccW-1]) begin
            word_q <= 32'd0;
            err_q  <= 1'b1;
            end_q  <= 1'b1;
          end else begin
            word_q <= padded[31:0];
            err_q  <= 1'b0;
            end_q  <= s2_last_q;
          end
        end
        default: begin
          word_q <= 32'd0;
          err_q  <= 1'b1;
          end_q  <= 1'b1;
        end
      endcase
    end else if (out_acc) begin
      word_q <= {word_q[23:0], 8'd0};
    end
  end

  assign byte_out_o   = word_q[31:24];
  assign is_error_o   = err_q;
  assign item_last_o  = (rem_q == 3'd1);
  assign stream_end_o = (rem_q == 3'd1) && end_q;

  // ---------------- checks
  `ASSERT_AT(a_err_word, clk_i, rst_ni,
    (out_valid_o && is_error_o) |-> (byte_out_o == 8'd0 && item_last_o && stream_end_o),
    "error word must be a zero byte closing the stream")
  `ASSERT_AT(a_drop_empty, clk_i, rst_ni,
    disc_q |-> (cnt_q == 3'd0 && grp_q == '0),
    "group must be clear while dropping input")
  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni,
    cnt_q > 3'd4 || (cnt_q == 3'd0 && grp_q != '0),
    "group count out of range or stale value at group start")
  `ASSERT_AT(a_drain, clk_i, rst_ni,
    (out_acc && rem_q == 3'd1 && !s2_adv) |=> !out_valid_o,
    "output must empty after its last byte is taken")

endmodule
